// ===== design/segmented_prime_sieve_top_macros.svh =====
// Assertion macros shared by the prime sieve RTL.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef SEGMENTED_PRIME_SIEVE_TOP_MACROS_SVH
`define SEGMENTED_PRIME_SIEVE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define PSV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sieve assertion failed");
// Condition must never be true outside reset
`define PSV_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("sieve forbidden condition seen");
`else
`define PSV_ASSERT(lbl, prop)
`define PSV_NEVER(lbl, cond)
`endif
`endif

// ===== design/psv_pkg.sv =====
// Shared types and constants for the segmented prime sieve.
// No dependencies.
package psv_pkg;

  // Register indexes of the configuration port
  localparam logic [0:0] REG_RANGE_LOW  = 1'd0;
  localparam logic [0:0] REG_RANGE_HIGH = 1'd1;

  // Smallest number searched
  localparam int unsigned LOW_FLOOR = 2;

  // One result of a pull
  typedef struct packed {
    logic        found;
    logic [31:0] prime;
    logic        last;
    logic        err;
  } res_t;

endpackage

// ===== design/psv_rem.sv =====
// Iterative remainder unit, one numerator bit per cycle (restoring).
// Depends on nothing.
module psv_rem #(
  parameter int NW = 33,
  parameter int DW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [DW-1:0] rem_o
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   num_q, num_d;
  logic [DW-1:0]   den_q, den_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DW:0]     trial;

  // One restoring step
  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    trial  = {rem_q, num_q[NW-1]};
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = CNTW'(NW);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = DW'(trial - {1'b0, den_q});
      end else begin
        rem_d = DW'(trial);
      end
      num_d = num_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== design/psv_core.sv =====
// Sieve engine: base and window bitmap memories and their sequencer.
// Depends on psv_pkg, psv_rem and segmented_prime_sieve_top_macros.svh.
`include "segmented_prime_sieve_top_macros.svh"
module psv_core #(
  parameter int WINDOW_SIZE = 65536,
  parameter int BASE_LIMIT  = 65536,
  parameter int VALUE_BITS  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_wr_i,
  input  logic [VALUE_BITS-1:0] range_low_i,
  input  logic [VALUE_BITS-1:0] range_high_i,
  input  logic                  pull_i,
  input  logic                  restart_i,
  output logic                  ready_o,
  output logic                  res_valid_o,
  output psv_pkg::res_t         res_o
);

  localparam int VB = VALUE_BITS;
  localparam int WA = $clog2(WINDOW_SIZE);
  localparam int WB = WA + 1;
  localparam int BA = $clog2(BASE_LIMIT);
  localparam int IW = BA + 1;
  localparam int SW = 2 * IW;
  localparam int JW = ((VB > SW) ? VB : SW) + 2;
  localparam logic [JW-1:0] BL_SQ  = JW'(BASE_LIMIT) * JW'(BASE_LIMIT);
  localparam logic [JW-1:0] WIN_SZ = JW'(WINDOW_SIZE);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BINIT = 4'd1;
  localparam logic [3:0] S_WINIT = 4'd2;
  localparam logic [3:0] S_IREAD = 4'd3;
  localparam logic [3:0] S_ICHK  = 4'd4;
  localparam logic [3:0] S_BSTR  = 4'd5;
  localparam logic [3:0] S_WDIV  = 4'd6;
  localparam logic [3:0] S_WSTR  = 4'd7;
  localparam logic [3:0] S_SCAN  = 4'd8;
  localparam logic [3:0] S_SCHK  = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0]    state_q, state_d;
  logic          done_q, done_d;
  logic          phase_q, phase_d;
  logic [IW-1:0] i_q, i_d;
  logic [IW-1:0] r_q, r_d;
  logic [SW-1:0] sq_q, sq_d;
  logic [JW-1:0] j_q, j_d;
  logic [VB:0]   n_q, n_d;
  logic [WB-1:0] c_q, c_d;
  logic [WB-1:0] cur_q, cur_d;
  logic [WB-1:0] idx_q, idx_d;

  // Range bounds and status
  logic [VB-1:0] lo;
  logic [JW-1:0] lo_j, hi_j, wfull;
  logic          empty, range_err;
  logic [WB-1:0] width;

  assign lo = (range_low_i < VB'(psv_pkg::LOW_FLOOR)) ? VB'(psv_pkg::LOW_FLOOR) : range_low_i;
  assign lo_j      = JW'(lo);
  assign hi_j      = JW'(range_high_i);
  assign wfull     = hi_j - lo_j + JW'(1);
  assign empty     = range_high_i < lo;
  assign range_err = (wfull > WIN_SZ) || (hi_j >= BL_SQ);
  assign width     = WB'(wfull);

  // Memories
  logic          base_mem [BASE_LIMIT];
  logic          win_mem  [WINDOW_SIZE];
  logic          base_we, base_wd, base_rd_q;
  logic [BA-1:0] base_wa;
  logic          win_we, win_wd, win_rd_q;
  logic [WA-1:0] win_wa;

  always_ff @(posedge clk_i) begin
    if (base_we) begin
      base_mem[base_wa] <= base_wd;
    end
    base_rd_q <= base_mem[i_q[BA-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[win_wa] <= win_wd;
    end
    win_rd_q <= win_mem[c_q[WA-1:0]];
  end

  // Remainder unit for the first window multiple
  logic          div_start, div_done;
  logic [IW-1:0] div_rem;
  logic [VB:0]   n_new;
  logic [JW-1:0] s_val;
  logic [SW-1:0] sq_next;

  assign n_new   = {1'b0, lo} + (VB + 1)'(i_q) - (VB + 1)'(1);
  assign s_val   = JW'(n_q) - JW'(div_rem);
  assign sq_next = sq_q + SW'({i_q, 1'b1});

  psv_rem #(
    .NW(VB + 1),
    .DW(IW)
  ) u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (n_new),
    .den_i  (i_q),
    .done_o (div_done),
    .rem_o  (div_rem)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    done_d      = done_q;
    phase_d     = phase_q;
    i_d         = i_q;
    r_d         = r_q;
    sq_d        = sq_q;
    j_d         = j_q;
    n_d         = n_q;
    c_d         = c_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    base_we     = 1'b0;
    base_wd     = 1'b0;
    base_wa     = i_q[BA-1:0];
    win_we      = 1'b0;
    win_wd      = 1'b0;
    win_wa      = c_q[WA-1:0];
    div_start   = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (cfg_wr_i) begin
          done_d = 1'b0;
        end else if (pull_i) begin
          if (restart_i) begin
            done_d = 1'b0;
          end
          if (empty) begin
            res_valid_o = 1'b1;
          end else if (range_err) begin
            res_valid_o = 1'b1;
            res_o.err   = 1'b1;
          end else if (restart_i || !done_q) begin
            i_d     = '0;
            sq_d    = '0;
            state_d = S_BINIT;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      // Mark base entries below the square-root bound as prime
      S_BINIT: begin
        if (JW'(sq_q) <= hi_j) begin
          base_we = 1'b1;
          base_wd = 1'b1;
          i_d     = i_q + 1'b1;
          sq_d    = sq_next;
        end else begin
          r_d     = i_q;
          c_d     = '0;
          state_d = S_WINIT;
        end
      end
      S_WINIT: begin
        if (c_q < width) begin
          win_we = 1'b1;
          win_wd = 1'b1;
          c_d    = c_q + 1'b1;
        end else begin
          i_d     = IW'(2);
          sq_d    = SW'(4);
          state_d = S_IREAD;
        end
      end
      S_IREAD: begin
        if (JW'(sq_q) > hi_j) begin
          c_d     = '0;
          phase_d = 1'b0;
          state_d = S_SCAN;
        end else begin
          state_d = S_ICHK;
        end
      end
      S_ICHK: begin
        if (!base_rd_q) begin
          i_d     = i_q + 1'b1;
          sq_d    = sq_next;
          state_d = S_IREAD;
        end else begin
          div_start = 1'b1;
          n_d       = n_new;
          j_d       = JW'(sq_q);
          state_d   = S_BSTR;
        end
      end
      // Strike base multiples while the divider runs
      S_BSTR: begin
        if (j_q < JW'(r_q)) begin
          base_we = 1'b1;
          base_wa = j_q[BA-1:0];
          j_d     = j_q + JW'(i_q);
        end else begin
          state_d = S_WDIV;
        end
      end
      S_WDIV: begin
        if (div_done) begin
          j_d     = (s_val < JW'(sq_q)) ? JW'(sq_q) : s_val;
          state_d = S_WSTR;
        end
      end
      S_WSTR: begin
        if (j_q <= hi_j) begin
          win_we = 1'b1;
          win_wa = WA'(j_q - lo_j);
          j_d    = j_q + JW'(i_q);
        end else begin
          i_d     = i_q + 1'b1;
          sq_d    = sq_next;
          state_d = S_IREAD;
        end
      end
      // Find the next unstruck entry from c
      S_SCAN: begin
        if (c_q >= width) begin
          cur_d = c_q;
          if (!phase_q) begin
            done_d  = 1'b1;
            state_d = S_EMIT;
          end else begin
            res_valid_o = 1'b1;
            res_o.found = 1'b1;
            res_o.prime = 32'(lo + VB'(idx_q));
            res_o.last  = 1'b1;
            state_d     = S_IDLE;
          end
        end else begin
          state_d = S_SCHK;
        end
      end
      S_SCHK: begin
        if (win_rd_q) begin
          cur_d = c_q;
          if (!phase_q) begin
            done_d  = 1'b1;
            state_d = S_EMIT;
          end else begin
            res_valid_o = 1'b1;
            res_o.found = 1'b1;
            res_o.prime = 32'(lo + VB'(idx_q));
            state_d     = S_IDLE;
          end
        end else begin
          c_d     = c_q + 1'b1;
          state_d = S_SCAN;
        end
      end
      S_EMIT: begin
        if (cur_q < width) begin
          idx_d   = cur_q;
          c_d     = cur_q + 1'b1;
          phase_d = 1'b1;
          state_d = S_SCAN;
        end else begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      cur_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      phase_q <= phase_d;
      cur_q   <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q   <= i_d;
    r_q   <= r_d;
    sq_q  <= sq_d;
    j_q   <= j_d;
    n_q   <= n_d;
    c_q   <= c_d;
    idx_q <= idx_d;
  end

  assign ready_o = (state_q == S_IDLE);

  `PSV_NEVER(a_found_with_err, res_valid_o && res_o.found && res_o.err)
  `PSV_NEVER(a_last_without_found, res_valid_o && res_o.last && !res_o.found)
  `PSV_ASSERT(a_result_returns_idle, res_valid_o |=> state_q == S_IDLE)
  `PSV_ASSERT(a_div_start_from_check, div_start |-> state_q == S_ICHK)

endmodule

// ===== design/segmented_prime_sieve_top.sv =====
// Segmented prime sieve: configuration registers, stream channels, output register.
// Depends on psv_pkg, psv_core and segmented_prime_sieve_top_macros.svh.
//
// Usage: write range_low (index 0) and range_high (index 1) through cfg_we_i,
// cfg_idx_i and cfg_wdata_i while the block is idle. Each input transfer on
// s_axis (tdata bit 0 = restart) pulls one result on m_axis: tdata is the
// prime, tuser bit 0 = found, bit 1 = range error, tlast marks the last prime.
// The first pull after a register write or a restart runs the sieve: it marks
// the base entries up to floor(sqrt(high)) and every window entry, then reads
// each base candidate from 2 up to that bound, and for each base prime runs
// the remainder unit (the base strikes overlap it) and strikes its window multiples.
// A first scan then walks the window to the first prime.
// A later pull scans on from the last prime to the next one, or to the end of
// the range, before the output register loads; an exhausted range loads it
// from the emit state, and an empty or erroneous range loads it at the
// transfer edge itself.
// One item is in work at a time; s_axis_tready is low while the core runs the sieve
// or a scan, or while a result waits in the output register for m_axis_tready.
// Reset clears both bounds, the cursor and the sieve-done flag; the bitmap
// memories are not cleared, they are written before being read.
`include "segmented_prime_sieve_top_macros.svh"
module segmented_prime_sieve_top #(
  parameter int WINDOW_SIZE = 65536,
  parameter int BASE_LIMIT  = 65536,
  parameter int VALUE_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] prime_value
  output logic [1:0]  m_axis_tuser,   // [0] found, [1] range_error
  output logic        m_axis_tlast    // is_last
);

  logic [VALUE_BITS-1:0] low_q, high_q;
  logic                  core_ready, res_valid, pull;
  psv_pkg::res_t         res;
  psv_pkg::res_t         out_q;
  logic                  out_valid_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        psv_pkg::REG_RANGE_LOW:  low_q  <= VALUE_BITS'(cfg_wdata_i);
        psv_pkg::REG_RANGE_HIGH: high_q <= VALUE_BITS'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  assign s_axis_tready = core_ready && !out_valid_q;
  assign pull          = s_axis_tvalid && s_axis_tready;

  psv_core #(
    .WINDOW_SIZE(WINDOW_SIZE),
    .BASE_LIMIT (BASE_LIMIT),
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_i    (cfg_we_i),
    .range_low_i (low_q),
    .range_high_i(high_q),
    .pull_i      (pull),
    .restart_i   (s_axis_tdata[0]),
    .ready_o     (core_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.prime;
  assign m_axis_tuser  = {out_q.err, out_q.found};
  assign m_axis_tlast  = out_q.last;

  `PSV_NEVER(a_no_overwrite, res_valid && out_valid_q)
  `PSV_NEVER(a_ready_while_full, s_axis_tready && out_valid_q)
  `PSV_ASSERT(a_result_after_pull, res_valid |-> !out_valid_q && $past(core_ready) |-> 1'b1)
  `PSV_ASSERT(a_pull_blocks_next, pull && !res_valid |=> !s_axis_tready)

endmodule
